/* hw/rtl/kmd_pkg.sv */
package kmd_pkg;

  // Default matrix geometry
  localparam int ROWS_DEFAULT = 8;
  localparam int COLS_DEFAULT = 16;

  // Settle count after reset
  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

  localparam logic [7:0] KEY_COUNT_MAX = 8'hFF;

  // One sampled row from the scanning front end
  typedef struct packed {
    logic [2:0]  row_index;
    logic [15:0] column_bits;
    logic        end_of_scan;
  } in_item_t;

  // One result: stable view of the sampled row plus matrix status
  typedef struct packed {
    logic [15:0] stable_row;
    logic        settled;
    logic        bounce;
    logic [7:0]  key_count;
  } out_item_t;

endpackage

/* hw/rtl/kmd_core.sv */
module kmd_core #(
  parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int COLS = kmd_pkg::COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 step_en,
  input  kmd_pkg::in_item_t    item,
  output kmd_pkg::out_item_t   res
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TOT_W = $clog2(ROWS * COLS + 1);

  logic [COLS-1:0]  raw_rows    [ROWS];
  logic [COLS-1:0]  stable_rows [ROWS];
  logic [7:0]       debounce_scans;
  logic [7:0]       settle_count;
  logic [TOT_W-1:0] raw_total;
  logic [TOT_W-1:0] stable_total;

  logic [31:0]      row_ext;
  logic [31:0]      col_ext;
  logic             row_ok;
  logic [ROW_W-1:0] idx;
  logic [COLS-1:0]  cols;
  logic             changed;
  logic [7:0]       reload;
  logic [7:0]       cnt_mid;
  logic [7:0]       settle_count_next;
  logic             copy;
  logic [5:0]       pc_old;
  logic [5:0]       pc_new;
  logic [31:0]      sum32;
  logic [TOT_W-1:0] raw_total_next;
  logic [TOT_W-1:0] stable_total_next;
  logic [31:0]      tot32;
  logic [31:0]      row_out;

  function automatic logic [5:0] popcnt(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

  always_comb begin
    row_ext = 32'(item.row_index);
    col_ext = 32'(item.column_bits);
    row_ok  = row_ext < 32'(ROWS);
    idx     = row_ext[ROW_W-1:0];
    cols    = col_ext[COLS-1:0];
    changed = row_ok && (raw_rows[idx] != cols);
    reload  = (debounce_scans == 8'd0) ? 8'd1 : debounce_scans;
    cnt_mid = changed ? reload : settle_count;

    // end-of-scan decrement follows the reload in the same step
    if (item.end_of_scan && (cnt_mid != 8'd0)) begin
      settle_count_next = cnt_mid - 8'd1;
    end else begin
      settle_count_next = cnt_mid;
    end
    copy = item.end_of_scan && (cnt_mid != 8'd0) && (settle_count_next == 8'd0);

    // pressed-key totals kept incrementally, one row differs per step
    pc_old = popcnt(32'(raw_rows[idx]));
    pc_new = popcnt(32'(cols));
    if (changed) begin
      sum32 = 32'(raw_total) - 32'(pc_old) + 32'(pc_new);
    end else begin
      sum32 = 32'(raw_total);
    end
    raw_total_next    = sum32[TOT_W-1:0];
    stable_total_next = copy ? raw_total_next : stable_total;
    tot32             = 32'(stable_total_next);

    row_out = copy ? 32'(cols) : 32'(stable_rows[idx]);

    res.stable_row = row_ok ? row_out[15:0] : 16'd0;
    res.settled    = (settle_count_next == 8'd0);
    res.bounce     = changed && (settle_count != 8'd0);
    res.key_count  = (tot32 > 32'(kmd_pkg::KEY_COUNT_MAX)) ? kmd_pkg::KEY_COUNT_MAX
                                                          : tot32[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= kmd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_scans <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= kmd_pkg::DEBOUNCE_RESET;
      raw_total    <= '0;
      stable_total <= '0;
      for (int r = 0; r < ROWS; r++) begin
        raw_rows[r]    <= '0;
        stable_rows[r] <= '0;
      end
    end else if (step_en) begin
      settle_count <= settle_count_next;
      raw_total    <= raw_total_next;
      stable_total <= stable_total_next;
      for (int r = 0; r < ROWS; r++) begin
        if (row_ok && (idx == ROW_W'(r))) begin
          raw_rows[r] <= cols;
        end
        if (copy) begin
          stable_rows[r] <= (row_ok && (idx == ROW_W'(r))) ? cols : raw_rows[r];
        end
      end
    end
  end

  // bounce only when the counter was still running
  a_bounce_needs_count: assert property (@(posedge clk) disable iff (rst)
    step_en && res.bounce |-> settle_count != 8'd0)
    else $error("bounce reported with idle settle counter");

  // a settled result leaves the counter at zero
  a_settled_zero: assert property (@(posedge clk) disable iff (rst)
    step_en && res.settled |=> settle_count == 8'd0)
    else $error("settled reported but counter nonzero");

  // totals never exceed the matrix size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(raw_total) <= 32'(ROWS * COLS) && 32'(stable_total) <= 32'(ROWS * COLS))
    else $error("key total out of range");

  // copy makes the stable total equal the raw total
  a_copy_totals: assert property (@(posedge clk) disable iff (rst)
    step_en && copy |=> stable_total == raw_total)
    else $error("stable total not taken from raw total on copy");

endmodule

/* hw/rtl/key_matrix_debouncer.sv */
// Path: an input transaction passes the input reg and then the result reg to become a result transaction.
// Throughput: one transaction per cycle while out_ready does not stall; the row compare, counter
//   update and incremental key totals all sit in the single stage between the two registers.
// Reset (rst, synchronous, active high): raw and stable stores cleared, key totals
//   zero, settle counter and debounce_scans at 5, both pipeline registers empty.
module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int COLS = kmd_pkg::COLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kmd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kmd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  // Input register: holds one accepted row sample
  logic               s1_valid;
  kmd_pkg::in_item_t  s1_item;

  // Result from the update logic, registered into out_data
  kmd_pkg::out_item_t step_res;

  logic out_free;   // result register empty or being drained this cycle
  logic step_en;    // stage-1 transaction moves into the result register
  logic in_take;

  assign out_free = !out_valid || out_ready;
  assign step_en  = s1_valid && out_free;
  // the input side keeps flowing as long as stage 1 can hand on
  assign in_ready = !s1_valid || step_en;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_data;
    end
  end

  // State stores, settle counter and result computation; state advances only
  // when the transaction leaves stage 1, so consecutive rows see each update.
  kmd_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .item      (s1_item),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= step_res;
    end
  end

endmodule
